// ----- rtl/bollinger_band_stream_macros.svh -----
// assertion helpers used by bbs_engine
`ifndef BOLLINGER_BAND_STREAM_MACROS_SVH
`define BOLLINGER_BAND_STREAM_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define BBS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bbs_pkg.sv -----
package bbs_pkg;

	// configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT  = 2'd1;

	localparam int WLEN_W = 11;
	localparam int MULT_W = 12;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd20;
	localparam logic [MULT_W-1:0] MULT_RESET = 12'd512;

	// fixed-point formats
	localparam int FRAC_W    = 8;
	localparam int VAR_FRAC  = 16;
	localparam int MID_W     = 32;
	localparam int BAND_W    = 36;

	// one result beat
	typedef struct packed {
		logic                     valid_res;
		logic [MID_W-1:0]         mean_band;
		logic [BAND_W-1:0]        high_band;
		logic signed [BAND_W-1:0] low_band;
	} bbs_res_t;

endpackage

// ----- rtl/bbs_if.sv -----
// input channel: one price sample per beat
interface bbs_in_if #(parameter int PRICE_BITS = 24);
	logic                  valid;
	logic                  ready;
	logic [PRICE_BITS-1:0] price;
	logic                  series_start;

	modport source (output valid, price, series_start, input ready);
	modport sink (input valid, price, series_start, output ready);
endinterface

// output channel: one band result per beat
interface bbs_out_if import bbs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     valid_res;
	logic [MID_W-1:0]         mean_band;
	logic [BAND_W-1:0]        high_band;
	logic signed [BAND_W-1:0] low_band;

	modport source (output valid, valid_res, mean_band, high_band, low_band, input ready);
	modport sink (input valid, valid_res, mean_band, high_band, low_band, output ready);
endinterface

// ----- rtl/bbs_alu.sv -----
module bbs_alu #(
	parameter int W = 85
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] y,
	output logic         co
);

	// shared add/subtract; on subtract co high means a >= b
	always_comb begin
		{co, y} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
	end

endmodule

// ----- rtl/bbs_window_ram.sv -----
module bbs_window_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/bbs_engine.sv -----
`include "bollinger_band_stream_macros.svh"

module bbs_engine import bbs_pkg::*; #(
	parameter int WINDOW_MAX = 1024,
	parameter int PRICE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PRICE_BITS-1:0]             price,
	input  logic                              series_start,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]   win_len,
	input  logic [MULT_W-1:0]                 band_mult,
	input  logic                              series_clr,
	output logic                              res_valid,
	input  logic                              res_ready,
	output bbs_res_t                          res
);

	localparam int AWD = $clog2(WINDOW_MAX);
	localparam int LW  = $clog2(WINDOW_MAX+1);
	localparam int PW  = PRICE_BITS;
	localparam int SW  = PW + AWD;
	localparam int QW  = 2*PW + AWD;
	localparam int NW  = LW + QW;
	localparam int AW  = NW + VAR_FRAC;
	localparam int VW  = 2*PW + 16;
	localparam int RW  = VW / 2;
	localparam int CW  = $clog2(AW+1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_UPD  = 4'd2;
	localparam logic [3:0] ST_PREP = 4'd3;
	localparam logic [3:0] ST_MEAN = 4'd4;
	localparam logic [3:0] ST_SSQ  = 4'd5;
	localparam logic [3:0] ST_LSQ  = 4'd6;
	localparam logic [3:0] ST_NSUB = 4'd7;
	localparam logic [3:0] ST_VD1  = 4'd8;
	localparam logic [3:0] ST_VD2  = 4'd9;
	localparam logic [3:0] ST_SQRT = 4'd10;
	localparam logic [3:0] ST_WID  = 4'd11;
	localparam logic [3:0] ST_UPB  = 4'd12;
	localparam logic [3:0] ST_LOB  = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	logic [3:0]      st_q;
	logic [PW-1:0]   price_q;
	logic [2*PW-1:0] psq_q;
	logic [SW-1:0]   sum_q;
	logic [QW-1:0]   sumsq_q;
	logic [LW-1:0]   fill_q;
	logic [AWD-1:0]  wp_q;
	logic [AW-1:0]   acc_q;
	logic [AW-1:0]   sh_q;
	logic [AW-1:0]   opnd_q;
	logic [CW-1:0]   cnt_q;
	logic [2*SW-1:0] ssq_q;
	logic [SW+7:0]   mean_q;
	logic            rv_q;
	bbs_res_t        res_q;

	logic [AWD-1:0]  old_pos;
	logic [PW-1:0]   rdata;
	logic            full;
	logic [PW-1:0]   old;
	logic [PW-1:0]   mul_in;
	logic [2*PW-1:0] mul_p;
	logic [2*PW-1:0] osq;
	logic [SW-1:0]   sum_n;
	logic [QW-1:0]   sumsq_n;
	logic [LW-1:0]   fill_inc;
	logic            vnew;
	logic            last;

	logic [AW-1:0]   alu_a;
	logic [AW-1:0]   alu_b;
	logic            alu_sub;
	logic [AW-1:0]   alu_y;
	logic            alu_co;

	logic [AW-1:0]   mul_add;
	logic [AW-1:0]   div_r2;
	logic [AW-1:0]   div_acc_n;
	logic [AW-1:0]   div_sh_n;
	logic [AW-1:0]   sq_r2;
	logic [AW-1:0]   sq_t;
	logic [AW-1:0]   sq_acc_n;
	logic [AW-1:0]   sq_root_n;
	logic [BAND_W-1:0] width_w;

	assign in_ready  = (st_q == ST_IDLE);
	assign res_valid = rv_q;
	assign res       = res_q;

	// slot of the sample that leaves the window
	always_comb begin
		if (LW'(wp_q) >= win_len) begin
			old_pos = AWD'(LW'(wp_q) - win_len);
		end else begin
			old_pos = AWD'((LW+1)'(wp_q) + (LW+1)'(WINDOW_MAX) - (LW+1)'(win_len));
		end
	end

	bbs_window_ram #(
		.DEPTH (WINDOW_MAX),
		.DW    (PW)
	) u_ram (
		.clk   (clk),
		.we    (st_q == ST_UPD),
		.waddr (wp_q),
		.wdata (price_q),
		.raddr (old_pos),
		.rdata (rdata)
	);

	// running sums update, one squarer shared by new and old sample
	always_comb begin
		full     = (fill_q >= win_len);
		old      = full ? rdata : '0;
		mul_in   = (st_q == ST_RD) ? price_q : rdata;
		mul_p    = (2*PW)'(mul_in) * (2*PW)'(mul_in);
		osq      = full ? mul_p : '0;
		sum_n    = sum_q - SW'(old) + SW'(price_q);
		sumsq_n  = sumsq_q - QW'(osq) + QW'(psq_q);
		fill_inc = fill_q + LW'(1);
		vnew     = full || (fill_inc == win_len);
		last     = (cnt_q == CW'(1));
	end

	// operand steering for the shared adder
	always_comb begin
		mul_add = sh_q[AW-1] ? opnd_q : '0;
		div_r2  = {acc_q[AW-2:0], sh_q[AW-1]};
		sq_r2   = {acc_q[AW-3:0], sh_q[AW-1:AW-2]};
		sq_t    = {opnd_q[AW-3:0], 2'b01};
		width_w = BAND_W'(acc_q >> FRAC_W);
		unique case (st_q) inside
			ST_MEAN, ST_VD1, ST_VD2: begin
				alu_a = div_r2; alu_b = opnd_q; alu_sub = 1'b1;
			end
			ST_SSQ, ST_LSQ, ST_WID: begin
				alu_a = acc_q << 1; alu_b = mul_add; alu_sub = 1'b0;
			end
			ST_NSUB: begin
				alu_a = acc_q; alu_b = AW'(ssq_q); alu_sub = 1'b1;
			end
			ST_SQRT: begin
				alu_a = sq_r2; alu_b = sq_t; alu_sub = 1'b1;
			end
			ST_UPB: begin
				alu_a = AW'(mean_q); alu_b = AW'(width_w); alu_sub = 1'b0;
			end
			ST_LOB: begin
				alu_a = AW'(mean_q); alu_b = AW'(width_w); alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0; alu_b = '0; alu_sub = 1'b0;
			end
		endcase
	end

	bbs_alu #(.W(AW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y),
		.co  (alu_co)
	);

	// per-step results of divide and square root
	always_comb begin
		div_acc_n = alu_co ? alu_y : div_r2;
		div_sh_n  = {sh_q[AW-2:0], alu_co};
		sq_acc_n  = alu_co ? alu_y : sq_r2;
		sq_root_n = {opnd_q[AW-2:0], alu_co};
	end

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			fill_q  <= '0;
			wp_q    <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (series_clr || (in_valid && series_start)) begin
						fill_q  <= '0;
						wp_q    <= '0;
						sum_q   <= '0;
						sumsq_q <= '0;
					end
					if (in_valid) begin
						st_q <= ST_RD;
					end
				end
				ST_RD: st_q <= ST_UPD;
				ST_UPD: begin
					sum_q   <= sum_n;
					sumsq_q <= sumsq_n;
					fill_q  <= full ? win_len : fill_inc;
					wp_q    <= (wp_q == AWD'(WINDOW_MAX-1)) ? '0 : wp_q + AWD'(1);
					if (vnew) begin
						st_q <= ST_PREP;
					end else begin
						st_q <= ST_OUT;
						rv_q <= 1'b1;
					end
				end
				ST_PREP: st_q <= ST_MEAN;
				ST_MEAN: if (last) st_q <= ST_SSQ;
				ST_SSQ:  if (last) st_q <= ST_LSQ;
				ST_LSQ:  if (last) st_q <= ST_NSUB;
				ST_NSUB: st_q <= ST_VD1;
				ST_VD1:  if (last) st_q <= ST_VD2;
				ST_VD2:  if (last) st_q <= ST_SQRT;
				ST_SQRT: if (last) st_q <= ST_WID;
				ST_WID:  if (last) st_q <= ST_UPB;
				ST_UPB:  st_q <= ST_LOB;
				ST_LOB: begin
					st_q <= ST_OUT;
					rv_q <= 1'b1;
				end
				ST_OUT: begin
					if (res_ready) begin
						rv_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the iterative unit
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_valid) price_q <= price;
			ST_RD:   psq_q <= mul_p;
			ST_UPD:  if (!vnew) res_q <= '0;
			ST_PREP: begin
				sh_q   <= AW'(sum_q) << (AW - SW);
				acc_q  <= '0;
				opnd_q <= AW'(win_len);
				cnt_q  <= CW'(SW + FRAC_W);
			end
			ST_MEAN: begin
				if (last) begin
					mean_q <= (SW+8)'(div_sh_n);
					sh_q   <= AW'(sum_q) << (AW - SW);
					acc_q  <= '0;
					opnd_q <= AW'(sum_q);
					cnt_q  <= CW'(SW);
				end else begin
					acc_q <= div_acc_n;
					sh_q  <= div_sh_n;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			ST_SSQ: begin
				if (last) begin
					ssq_q  <= (2*SW)'(alu_y);
					sh_q   <= AW'(win_len) << (AW - LW);
					acc_q  <= '0;
					opnd_q <= AW'(sumsq_q);
					cnt_q  <= CW'(LW);
				end else begin
					acc_q <= alu_y;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			ST_LSQ, ST_WID: begin
				acc_q <= alu_y;
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
			ST_NSUB: begin
				sh_q   <= alu_y << VAR_FRAC;
				acc_q  <= '0;
				opnd_q <= AW'(win_len);
				cnt_q  <= CW'(AW);
			end
			ST_VD1: begin
				if (last) begin
					sh_q  <= div_sh_n << (AW - QW - VAR_FRAC);
					acc_q <= '0;
					cnt_q <= CW'(QW + VAR_FRAC);
				end else begin
					acc_q <= div_acc_n;
					sh_q  <= div_sh_n;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			ST_VD2: begin
				if (last) begin
					sh_q   <= AW'(div_sh_n[VW-1:0]) << (AW - VW);
					acc_q  <= '0;
					opnd_q <= '0;
					cnt_q  <= CW'(RW);
				end else begin
					acc_q <= div_acc_n;
					sh_q  <= div_sh_n;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			ST_SQRT: begin
				if (last) begin
					sh_q   <= AW'(band_mult) << (AW - MULT_W);
					acc_q  <= '0;
					opnd_q <= AW'(sq_root_n[RW-1:0]);
					cnt_q  <= CW'(MULT_W);
				end else begin
					acc_q  <= sq_acc_n;
					opnd_q <= sq_root_n;
					sh_q   <= sh_q << 2;
					cnt_q  <= cnt_q - CW'(1);
				end
			end
			ST_UPB: begin
				res_q.valid_res <= 1'b1;
				res_q.mean_band <= MID_W'(mean_q);
				res_q.high_band <= BAND_W'(alu_y);
			end
			ST_LOB: res_q.low_band <= BAND_W'(alu_y);
			default: ;
		endcase
	end

	`BBS_ASSERT_IMP(a_fill_bound, st_q == ST_IDLE, fill_q <= win_len, "fill count above window")
	`BBS_ASSERT_IMP(a_zero_res, rv_q && !res_q.valid_res, res_q.mean_band == '0 && res_q.high_band == '0 && res_q.low_band == '0, "early result not zero")
	`BBS_ASSERT_NXT(a_accept_rd, in_valid && in_ready, st_q == ST_RD, "accepted beat did not start")
	`BBS_ASSERT_NXT(a_out_done, rv_q && res_ready, !rv_q && st_q == ST_IDLE, "result beat not retired")

endmodule

// ----- rtl/bollinger_band_stream.sv -----
// Price band stream: SMA middle band with upper/lower bands at
// band_mult (Q4.8) times the population standard deviation, mean Q24.8 out.
// Channels: in_ch (sink) takes one beat per price sample with a
// series_start flag; out_ch (source) gives one beat per sample.
// Config: cfg_we/cfg_idx/cfg_wdata write window_len (index 0, also
// clears the series) or band_mult (index 1); write only while idle.
// A beat before the window fills returns zeros with valid_res low.
// A full-window beat runs the shared add/subtract unit through the
// mean divide, a square of the sum, a multiply of the sum of squares
// by the window length, two divides by the window length, a square
// root, the band multiply and the band add and subtract. One item is
// in flight at a time: a new sample is taken only once the result
// beat of the last has been taken.
// Reset: window empty, sums zero, window_len 20, band_mult 512; the
// window memory needs no clearing pass.
// A stalled receiver holds the result beat and blocks the next input.
module bollinger_band_stream import bbs_pkg::*; #(
	parameter int WINDOW_MAX = 1024,
	parameter int PRICE_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bbs_in_if.sink               in_ch,
	bbs_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [MULT_W-1:0]    cfg_wdata
);

	localparam int LW = $clog2(WINDOW_MAX+1);

	logic [WLEN_W-1:0] wlen_q;
	logic [MULT_W-1:0] mult_q;
	logic [LW-1:0]     eff_len;
	logic              clr;
	bbs_res_t          res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			mult_q <= MULT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_LEN: wlen_q <= cfg_wdata[WLEN_W-1:0];
				REG_BAND_MULT:  mult_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign clr = cfg_we && (cfg_idx == REG_WINDOW_LEN);

	// window length limited to 1..WINDOW_MAX
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = LW'(1);
		end else if (32'(wlen_q) > WINDOW_MAX) begin
			eff_len = LW'(WINDOW_MAX);
		end else begin
			eff_len = LW'(wlen_q);
		end
	end

	bbs_engine #(
		.WINDOW_MAX (WINDOW_MAX),
		.PRICE_BITS (PRICE_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.price        (in_ch.price),
		.series_start (in_ch.series_start),
		.win_len      (eff_len),
		.band_mult    (mult_q),
		.series_clr   (clr),
		.res_valid    (out_ch.valid),
		.res_ready    (out_ch.ready),
		.res          (res)
	);

	// result beat onto the output channel
	assign out_ch.valid_res = res.valid_res;
	assign out_ch.mean_band = res.mean_band;
	assign out_ch.high_band = res.high_band;
	assign out_ch.low_band  = res.low_band;

endmodule

// ----- tb/tb_bollinger_band_stream.sv -----
`timescale 1ns / 100ps

module tb_bollinger_band_stream;
	import bbs_pkg::*;

	localparam int WMAX = 1024;
	localparam int PBITS = 24;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [PBITS-1:0] price;
		logic             start;
	} sample_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [MULT_W-1:0]    cfg_wdata;

	bbs_in_if #(.PRICE_BITS(PBITS)) in_ch ();
	bbs_out_if out_ch ();

	bollinger_band_stream #(.WINDOW_MAX(WMAX), .PRICE_BITS(PBITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	sample_t  sample_q[$];
	bbs_res_t band_expect_q[$];
	int       idle_pct;
	int       stall_pct;
	int       mismatch_cnt = 0;
	int       cycle_cnt = 0;

	// band model state
	logic [PBITS-1:0]  win_mem[WMAX];
	int                wr_pos = 0;
	int                fill_cnt = 0;
	logic [127:0]      win_sum = '0;
	logic [127:0]      win_sum_sq = '0;
	logic [WLEN_W-1:0] win_len = WLEN_RESET;
	logic [MULT_W-1:0] dev_mult = MULT_RESET;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [127:0] floor_sqrt(logic [127:0] v);
		logic [127:0] res;
		logic [127:0] b;
		res = '0;
		b = 128'd1 << 126;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// advance the window by one sample and work out the bands
	function automatic bbs_res_t predict_bands(logic [PBITS-1:0] price, logic start);
		bbs_res_t     r;
		int           len;
		logic [127:0] old;
		logic [127:0] mean;
		logic [127:0] spread;
		logic [127:0] dev;
		logic [127:0] wdt;
		logic [127:0] up;
		logic [127:0] lo;
		len = (win_len == 0) ? 1 : ((win_len > WMAX) ? WMAX : int'(win_len));
		if (start) begin
			wr_pos = 0;
			fill_cnt = 0;
			win_sum = '0;
			win_sum_sq = '0;
		end
		if (fill_cnt >= len) begin
			old = 128'(win_mem[(wr_pos + WMAX - len) % WMAX]);
			win_sum = win_sum - old;
			win_sum_sq = win_sum_sq - old * old;
			fill_cnt = len;
		end else begin
			fill_cnt++;
		end
		win_sum = win_sum + 128'(price);
		win_sum_sq = win_sum_sq + 128'(price) * 128'(price);
		win_mem[wr_pos] = price;
		wr_pos = (wr_pos + 1) % WMAX;
		r = '0;
		if (fill_cnt < len) return r;
		mean = (win_sum << 8) / 128'(len);
		spread = 128'(len) * win_sum_sq - win_sum * win_sum;
		dev = floor_sqrt((spread << 16) / (128'(len) * 128'(len)));
		wdt = (dev * 128'(dev_mult)) >> 8;
		up = mean + wdt;
		lo = mean - wdt;
		r.valid_res = 1'b1;
		r.mean_band = mean[MID_W-1:0];
		r.high_band = up[BAND_W-1:0];
		r.low_band = lo[BAND_W-1:0];
		return r;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.price <= '0;
			in_ch.series_start <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.price <= sample_q[0].price;
				in_ch.series_start <= sample_q[0].start;
				sample_q.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// mirror register writes, predict on each input beat, check each result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_idx == REG_WINDOW_LEN) begin
					win_len = cfg_wdata[WLEN_W-1:0];
					wr_pos = 0;
					fill_cnt = 0;
					win_sum = '0;
					win_sum_sq = '0;
				end else if (cfg_idx == REG_BAND_MULT) begin
					dev_mult = cfg_wdata;
				end
			end
			if (in_ch.valid && in_ch.ready)
				band_expect_q.push_back(predict_bands(in_ch.price, in_ch.series_start));
			if (out_ch.valid && out_ch.ready) begin
				if (band_expect_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result beat at cycle %0d", cycle_cnt);
				end else begin
					if (out_ch.valid_res !== band_expect_q[0].valid_res ||
					    out_ch.mean_band !== band_expect_q[0].mean_band ||
					    out_ch.high_band !== band_expect_q[0].high_band ||
					    out_ch.low_band !== band_expect_q[0].low_band) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch cycle %0d: exp v%0b m%0h u%0h l%0h %s",
								cycle_cnt, band_expect_q[0].valid_res,
								band_expect_q[0].mean_band, band_expect_q[0].high_band,
								band_expect_q[0].low_band,
								$sformatf("got v%0b m%0h u%0h l%0h",
									out_ch.valid_res, out_ch.mean_band,
									out_ch.high_band, out_ch.low_band));
					end
					band_expect_q.pop_front();
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_bollinger_band_stream NOT OK");
			$finish;
		end
	end

	task automatic wait_drained();
		while (sample_q.size() > 0 || in_ch.valid || band_expect_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MULT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_sample(logic [PBITS-1:0] p, logic s);
		sample_t it;
		it.price = p;
		it.start = s;
		sample_q.push_back(it);
	endtask

	// random prices: full range, tight cluster or extremes
	task automatic push_random(int n);
		int               kind;
		logic [PBITS-1:0] base;
		base = PBITS'($urandom);
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(9);
			if (kind < 4)
				push_sample(PBITS'($urandom), $urandom_range(60) == 0);
			else if (kind < 8)
				push_sample(PBITS'(base + $urandom_range(255)), $urandom_range(60) == 0);
			else
				push_sample(($urandom_range(1)) ? {PBITS{1'b1}} : '0, $urandom_range(60) == 0);
		end
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 74; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 74; end
			default: begin idle_pct = 27; stall_pct = 27; end
		endcase
	endtask

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		cfg_we = 1'b0;
		cfg_idx = REG_WINDOW_LEN;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, extremes, series restart
		for (int i = 0; i < 22; i++)
			push_sample((i % 2) ? {PBITS{1'b1}} : '0, 1'b0);
		push_sample(24'h123456, 1'b1);
		push_sample(24'hAAAAAA, 1'b0);
		push_sample(24'h555555, 1'b0);
		wait_drained();

		// unmapped register indexes change nothing
		write_reg(2'd2, 12'hFFF);
		write_reg(2'd3, 12'h000);

		// window of one, zero multiplier
		set_idling(1);
		write_reg(REG_WINDOW_LEN, 12'd1);
		write_reg(REG_BAND_MULT, 12'd0);
		push_random(100);
		wait_drained();

		// zero length acts as one, max multiplier
		set_idling(2);
		write_reg(REG_WINDOW_LEN, 12'd0);
		write_reg(REG_BAND_MULT, 12'hFFF);
		push_random(100);
		wait_drained();

		// window of two
		set_idling(3);
		write_reg(REG_WINDOW_LEN, 12'd2);
		write_reg(REG_BAND_MULT, 12'd256);
		push_random(150);
		wait_drained();

		// oversize length saturates to the full window
		set_idling(0);
		write_reg(REG_WINDOW_LEN, 12'd2047);
		write_reg(REG_BAND_MULT, 12'd300);
		push_random(1090);
		wait_drained();

		// assorted small windows and multipliers
		for (int ph = 0; ph < 8; ph++) begin
			set_idling(ph);
			write_reg(REG_WINDOW_LEN, 12'($urandom_range(2, 24)));
			write_reg(REG_BAND_MULT, 12'($urandom_range(4095)));
			push_random(40);
			wait_drained();
			// multiplier change mid-series keeps the window
			write_reg(REG_BAND_MULT, 12'($urandom_range(4095)));
			push_random(15);
			wait_drained();
		end

		if (mismatch_cnt == 0 && band_expect_q.size() == 0) begin
			$display("tb_bollinger_band_stream OK");
		end else begin
			$display("tb_bollinger_band_stream NOT OK");
		end
		$finish;
	end

endmodule
